>>> rtl/battery_voltage_monitor_assert.svh
// assertion helpers shared by the monitor rtl
// both expect i_clk and i_rst_n in the enclosing module
`ifndef BATTERY_VOLTAGE_MONITOR_ASSERT_SVH
`define BATTERY_VOLTAGE_MONITOR_ASSERT_SVH

// consequent checked in the same cycle
`define BVM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("battery voltage monitor check failed");

// consequent checked in the next cycle
`define BVM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("battery voltage monitor check failed");

`endif

>>> rtl/bvm_pkg.sv
package bvm_pkg;

    localparam int unsigned MV_W       = 16;
    localparam int unsigned Q16_W      = 32;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned TENTHS_W   = 11;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned AVG_LENGTH = 300;

    localparam logic [MV_W-1:0]  AVG_RESET_MV     = 16'd27000;
    localparam logic [Q16_W-1:0] AVG_RESET_Q16    = {AVG_RESET_MV, 16'h0000};
    localparam logic [Q16_W-1:0] AVG_MAX_Q16      = 32'hFFFF_0000;
    localparam logic [MV_W-1:0]  RUN_MIN_MV       = 16'd21000;
    localparam int unsigned      RUN_SPAN_MV      = 5500;
    localparam int unsigned      RUN_MV_PER_TENTH = 5;
    localparam int unsigned      RUN_TENTHS_MAX   = RUN_SPAN_MV / RUN_MV_PER_TENTH;
    localparam int unsigned      RUN_X_W          = $clog2(RUN_SPAN_MV + 1);
    localparam logic [CNT_W-1:0] CNT_MAX          = '1;

    // reciprocal for an exact floor(n / AVG_LENGTH) over 32-bit n
    localparam int unsigned AVG_SHIFT   = Q16_W + $clog2(AVG_LENGTH);
    localparam int unsigned AVG_RECIP_W = Q16_W + 2;
    localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
        AVG_RECIP_W'(((65'd1 << AVG_SHIFT) / AVG_LENGTH) + 1);

    // reciprocal for floor(x / 5) over the clamped run span
    localparam int unsigned TENTH_SHIFT   = RUN_X_W + $clog2(RUN_MV_PER_TENTH);
    localparam int unsigned TENTH_RECIP_W = RUN_X_W + 2;
    localparam logic [TENTH_RECIP_W-1:0] TENTH_RECIP =
        TENTH_RECIP_W'(((33'd1 << TENTH_SHIFT) / RUN_MV_PER_TENTH) + 1);

    typedef enum logic [1:0] {
        LVL_OK    = 2'd0,
        LVL_WARN  = 2'd1,
        LVL_ERROR = 2'd2,
        LVL_NONE  = 2'd3
    } t_level;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ERROR_LEVEL  = 3'd0,
        CFG_WARN_LEVEL   = 3'd1,
        CFG_CUTOFF_IDLE  = 3'd2,
        CFG_CUTOFF_MOVE  = 3'd3,
        CFG_LOW_LIMIT    = 3'd4,
        CFG_REPORT_EVERY = 3'd5,
        CFG_VALID_FLOOR  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [MV_W-1:0]  error_level_mv;
        logic [MV_W-1:0]  warn_level_mv;
        logic [MV_W-1:0]  cutoff_idle_mv;
        logic [MV_W-1:0]  cutoff_moving_mv;
        logic [CNT_W-1:0] low_count_limit;
        logic [CNT_W-1:0] report_every;
        logic [MV_W-1:0]  valid_floor_mv;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        error_level_mv:   16'd22000,
        warn_level_mv:    16'd23000,
        cutoff_idle_mv:   16'd21000,
        cutoff_moving_mv: 16'd19500,
        low_count_limit:  8'd40,
        report_every:     8'd10,
        valid_floor_mv:   16'd10000
    };

    // item entering the state stage
    typedef struct packed {
        logic [Q16_W-1:0] v_term;
        logic             motion;
        logic             moved;
    } t_stage_in;

    // per-item result leaving the state stage
    typedef struct packed {
        logic [MV_W-1:0] avg_mv;
        logic            report;
        t_level          level;
        logic            shutdown;
    } t_frame_res;

    function automatic logic [Q16_W-1:0] div_len(input logic [Q16_W-1:0] n);
        logic [Q16_W+AVG_RECIP_W-1:0] p;
        p = {{AVG_RECIP_W{1'b0}}, n} * {{Q16_W{1'b0}}, AVG_RECIP};
        return Q16_W'(p[Q16_W+AVG_RECIP_W-1:AVG_SHIFT]);
    endfunction

    function automatic logic [TENTHS_W-1:0] run_tenths(input logic [MV_W-1:0] avg_mv);
        logic [MV_W-1:0]                    diff;
        logic [RUN_X_W-1:0]                 x;
        logic [RUN_X_W+TENTH_RECIP_W-1:0]   p;
        diff = avg_mv - RUN_MIN_MV;
        if (avg_mv < RUN_MIN_MV) begin
            x = '0;
        end else if (diff >= MV_W'(RUN_SPAN_MV)) begin
            x = RUN_X_W'(RUN_SPAN_MV);
        end else begin
            x = diff[RUN_X_W-1:0];
        end
        p = {{TENTH_RECIP_W{1'b0}}, x} * {{RUN_X_W{1'b0}}, TENTH_RECIP};
        return p[TENTH_SHIFT +: TENTHS_W];
    endfunction

endpackage

>>> rtl/bvm_in_if.sv
interface bvm_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] voltage_mv;
    logic        commanded_motion;
    logic        moved_forward;

    modport source (output valid, output voltage_mv, output commanded_motion,
                    output moved_forward, input ready);
    modport sink   (input valid, input voltage_mv, input commanded_motion,
                    input moved_forward, output ready);
endinterface

>>> rtl/bvm_out_if.sv
interface bvm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] avg_voltage_mv;
    logic [10:0] remaining_tenths_min;
    logic        report_valid;
    logic [1:0]  level;
    logic        shutdown;

    modport source (output valid, output avg_voltage_mv, output remaining_tenths_min,
                    output report_valid, output level, output shutdown, input ready);
    modport sink   (input valid, input avg_voltage_mv, input remaining_tenths_min,
                    input report_valid, input level, input shutdown, output ready);
endinterface

>>> rtl/bvm_core.sv
`include "battery_voltage_monitor_assert.svh"

module bvm_core import bvm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_fire,
    input  t_stage_in  i_item,
    output t_frame_res o_res
);

    logic [Q16_W-1:0] r_avg;
    logic [CNT_W-1:0] r_frame_count;
    logic [CNT_W-1:0] r_low_count;
    logic             r_latch;
    t_frame_res       r_res;

    logic [Q16_W-1:0] n_avg;
    logic [CNT_W-1:0] n_frame_count;
    logic [CNT_W-1:0] n_low_count;
    logic             n_latch;
    t_frame_res       n_res;

    logic             report;
    logic [Q16_W:0]   avg_sum;
    logic [Q16_W-1:0] avg_upd;
    logic [MV_W-1:0]  cutoff;
    logic [CNT_W-1:0] low_inc;
    t_level           level;

    always_comb begin
        report        = !(r_frame_count < i_cfg.report_every);
        n_frame_count = report ? '0 : r_frame_count + CNT_W'(1);

        avg_sum = {1'b0, r_avg} - {1'b0, div_len(r_avg)} + {1'b0, i_item.v_term};
        avg_upd = (avg_sum > {1'b0, AVG_MAX_Q16}) ? AVG_MAX_Q16 : avg_sum[Q16_W-1:0];
        n_avg   = (report && !i_item.motion) ? avg_upd : r_avg;

        cutoff  = i_item.moved ? i_cfg.cutoff_moving_mv : i_cfg.cutoff_idle_mv;
        low_inc = (r_low_count != CNT_MAX) ? r_low_count + CNT_W'(1) : r_low_count;

        n_low_count = r_low_count;
        n_latch     = r_latch;
        if (n_avg > {i_cfg.valid_floor_mv, 16'h0000}) begin
            if (n_avg < {i_cfg.error_level_mv, 16'h0000}) begin
                level = LVL_ERROR;
            end else if (n_avg < {i_cfg.warn_level_mv, 16'h0000}) begin
                level = LVL_WARN;
            end else begin
                level = LVL_OK;
            end
            if (n_avg < {cutoff, 16'h0000}) begin
                n_low_count = low_inc;
                if (low_inc > i_cfg.low_count_limit) begin
                    n_latch = 1'b1;
                end
            end else if (r_low_count != '0) begin
                n_low_count = r_low_count - CNT_W'(1);
            end
        end else begin
            level = LVL_NONE;
        end

        n_res.avg_mv   = n_avg[Q16_W-1 -: MV_W];
        n_res.report   = report;
        n_res.level    = level;
        n_res.shutdown = n_latch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg         <= AVG_RESET_Q16;
            r_frame_count <= '0;
            r_low_count   <= '0;
            r_latch       <= 1'b0;
        end else if (i_fire) begin
            r_avg         <= n_avg;
            r_frame_count <= n_frame_count;
            r_low_count   <= n_low_count;
            r_latch       <= n_latch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

    `BVM_ASSERT_NEXT(a_latch_sticky, r_latch, r_latch)
    `BVM_ASSERT_NOW(a_avg_bounded, 1'b1, r_avg <= AVG_MAX_Q16)
    `BVM_ASSERT_NEXT(a_frame_step, i_fire && !report, r_frame_count == $past(r_frame_count) + 8'd1)

endmodule

>>> rtl/battery_voltage_monitor.sv
// throughput: one item per cycle while the output is not stalled; four register
// stages (input, sample scale, average/state, result), each advancing when the
// one after it advances or it is itself empty, so bubbles close up under backpressure
// reset (synchronous, active low): average 27000 mV, counters and latch clear,
// configuration registers to their defaults, pipeline empty
`include "battery_voltage_monitor_assert.svh"

module battery_voltage_monitor import bvm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bvm_in_if.sink                i_in,
    bvm_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ERROR_LEVEL:  r_cfg.error_level_mv   <= i_cfg_data;
                CFG_WARN_LEVEL:   r_cfg.warn_level_mv    <= i_cfg_data;
                CFG_CUTOFF_IDLE:  r_cfg.cutoff_idle_mv   <= i_cfg_data;
                CFG_CUTOFF_MOVE:  r_cfg.cutoff_moving_mv <= i_cfg_data;
                CFG_LOW_LIMIT:    r_cfg.low_count_limit  <= i_cfg_data[CNT_W-1:0];
                CFG_REPORT_EVERY: r_cfg.report_every     <= i_cfg_data[CNT_W-1:0];
                CFG_VALID_FLOOR:  r_cfg.valid_floor_mv   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline registers
    logic             r_s1_valid;
    logic [MV_W-1:0]  r_s1_v;
    logic             r_s1_motion;
    logic             r_s1_moved;
    logic             r_s2_valid;
    t_stage_in        r_s2_item;
    logic             r_s3_valid;
    logic             r_out_valid;
    logic [MV_W-1:0]  r_out_avg;
    logic [TENTHS_W-1:0] r_out_tenths;
    logic             r_out_report;
    t_level           r_out_level;
    logic             r_out_shutdown;

    logic       en_out;
    logic       en_s3;
    logic       en_s2;
    logic       en_s1;
    t_frame_res s3_res;
    t_stage_in  n_s2_item;

    // each stage advances when the one after it advances or when it is itself empty
    assign en_out = !r_out_valid || o_out.ready;
    assign en_s3  = en_out || !r_s3_valid;
    assign en_s2  = en_s3 || !r_s2_valid;
    assign en_s1  = en_s2 || !r_s1_valid;

    assign i_in.ready = en_s1;

    always_comb begin
        n_s2_item.v_term = div_len({r_s1_v, 16'h0000});
        n_s2_item.motion = r_s1_motion;
        n_s2_item.moved  = r_s1_moved;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_s1) begin
                r_s1_valid <= i_in.valid;
            end
            if (en_s2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (en_s3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (en_out) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_s1_v      <= i_in.voltage_mv;
            r_s1_motion <= i_in.commanded_motion;
            r_s1_moved  <= i_in.moved_forward;
        end
        if (en_s2) begin
            r_s2_item <= n_s2_item;
        end
        if (en_out) begin
            r_out_avg      <= s3_res.avg_mv;
            r_out_tenths   <= s3_res.report ? run_tenths(s3_res.avg_mv) : '0;
            r_out_report   <= s3_res.report;
            r_out_level    <= s3_res.level;
            r_out_shutdown <= s3_res.shutdown;
        end
    end

    bvm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_fire  (en_s3 && r_s2_valid),
        .i_item  (r_s2_item),
        .o_res   (s3_res)
    );

    assign o_out.valid                = r_out_valid;
    assign o_out.avg_voltage_mv       = r_out_avg;
    assign o_out.remaining_tenths_min = r_out_tenths;
    assign o_out.report_valid         = r_out_report;
    assign o_out.level                = r_out_level;
    assign o_out.shutdown             = r_out_shutdown;

    `BVM_ASSERT_NEXT(a_accept_lands, i_in.valid && i_in.ready, r_s1_valid)
    `BVM_ASSERT_NOW(a_quiet_tenths, r_out_valid && !r_out_report, r_out_tenths == '0)
    `BVM_ASSERT_NOW(a_tenths_range, r_out_valid, r_out_tenths <= TENTHS_W'(RUN_TENTHS_MAX))

endmodule
